@@ src/max_priority_queue_linear_scan_defines.svh @@
// Assertion macros used by the top-level file that checks the queue.
`ifndef MAX_PRIORITY_QUEUE_LINEAR_SCAN_DEFINES_SVH
`define MAX_PRIORITY_QUEUE_LINEAR_SCAN_DEFINES_SVH

`define MPQ_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("queue check failed in the same cycle");

`define MPQ_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("queue check failed in the following cycle");

`endif

@@ src/mpq_pkg.sv @@
package mpq_pkg;

   localparam int DEPTH = 16;
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int HELD_W = 5;

   localparam logic CMD_ENQ = 1'b0;
   localparam logic CMD_DEQ = 1'b1;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic cmd;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] removed;
      logic [1:0] status;
      logic signed [31:0] oldest;
      logic [HELD_W-1:0] held;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic [1:0] status;
      logic enq_wr;
      logic scan_start;
      logic scan_rd;
      logic shift_start;
      logic shift_rd;
      logic trim;
      logic head_rd;
      logic rsp_load;
   } dp_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic idx_last;
      logic pos_last;
      logic slot_free;
   } dp_stat_type;

endpackage

@@ src/mpq_datapath.sv @@
module mpq_datapath
   import mpq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  req_type     req_data,
   input  dp_cmd_type  cmd,
   output dp_stat_type stat,
   input  logic        rsp_ready,
   output logic        rsp_valid,
   output rsp_type     rsp_data
);

   logic [31:0] mem [DEPTH];
   logic [31:0] rdata_ff;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   logic [AW-1:0] idx_ff;
   logic [AW-1:0] idx_in;
   logic [AW-1:0] rd_addr;
   logic cmp_vld_ff;
   logic [AW-1:0] cmp_idx_ff;
   logic sh_vld_ff;
   logic [AW-1:0] sh_wa_ff;
   logic signed [31:0] best_ff;
   logic [AW-1:0] pos_ff;
   logic signed [31:0] removed_ff;
   logic [1:0] status_ff;
   logic rsp_valid_ff;
   rsp_type rsp_ff;
   logic [CW-1:0] last_idx;

   assign last_idx = count_ff - CW'(1);
   assign rd_addr = cmd.head_rd ? '0 : idx_ff;

   always_ff @(posedge clock) begin
      if (cmd.enq_wr) begin
         mem[count_ff[AW-1:0]] <= req_data.value;
      end else if (sh_vld_ff) begin
         mem[sh_wa_ff] <= rdata_ff;
      end
      if (cmd.scan_rd || cmd.shift_rd || cmd.head_rd) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.enq_wr) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.trim) begin
         count_in = count_ff - CW'(1);
      end
      idx_in = idx_ff;
      if (cmd.scan_start) begin
         idx_in = '0;
      end else if (cmd.shift_start) begin
         idx_in = pos_ff + AW'(1);
      end else if (cmd.scan_rd || cmd.shift_rd) begin
         idx_in = idx_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         cmp_vld_ff <= 1'b0;
         sh_vld_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         cmp_vld_ff <= cmd.scan_rd;
         sh_vld_ff <= cmd.shift_rd;
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      cmp_idx_ff <= idx_ff;
      sh_wa_ff <= idx_ff - AW'(1);
      if (cmp_vld_ff) begin
         if (cmp_idx_ff == '0 || $signed(rdata_ff) > best_ff) begin
            best_ff <= $signed(rdata_ff);
            pos_ff <= cmp_idx_ff;
         end
      end
      if (cmd.capture) begin
         status_ff <= cmd.status;
         removed_ff <= '0;
      end else if (cmd.trim) begin
         removed_ff <= best_ff;
      end
      if (cmd.rsp_load) begin
         rsp_ff.removed <= removed_ff;
         rsp_ff.status <= status_ff;
         rsp_ff.oldest <= (count_ff == '0) ? '0 : $signed(rdata_ff);
         rsp_ff.held <= HELD_W'(count_ff);
      end
   end

   assign stat.full = (count_ff >= CW'(DEPTH));
   assign stat.empty = (count_ff == '0);
   assign stat.idx_last = (CW'(idx_ff) == last_idx);
   assign stat.pos_last = (CW'(pos_ff) == last_idx);
   assign stat.slot_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule

@@ src/mpq_ctrl.sv @@
module mpq_ctrl
   import mpq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_cmd,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCAN,
      S_SCAN_END,
      S_PICK,
      S_SHIFT,
      S_SHIFT_END,
      S_TRIM,
      S_HEAD,
      S_HEAD_WAIT
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      cmd.status = ST_OK;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in = S_HEAD;
               if (req_cmd == CMD_ENQ) begin
                  if (stat.full) begin
                     cmd.status = ST_FULL;
                  end else begin
                     cmd.enq_wr = 1'b1;
                  end
               end else if (stat.empty) begin
                  cmd.status = ST_EMPTY;
               end else begin
                  cmd.scan_start = 1'b1;
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            cmd.scan_rd = 1'b1;
            if (stat.idx_last) begin
               state_in = S_SCAN_END;
            end
         end
         S_SCAN_END: begin
            state_in = S_PICK;
         end
         S_PICK: begin
            if (stat.pos_last) begin
               state_in = S_TRIM;
            end else begin
               cmd.shift_start = 1'b1;
               state_in = S_SHIFT;
            end
         end
         S_SHIFT: begin
            cmd.shift_rd = 1'b1;
            if (stat.idx_last) begin
               state_in = S_SHIFT_END;
            end
         end
         S_SHIFT_END: begin
            state_in = S_TRIM;
         end
         S_TRIM: begin
            cmd.trim = 1'b1;
            state_in = S_HEAD;
         end
         S_HEAD: begin
            cmd.head_rd = 1'b1;
            state_in = S_HEAD_WAIT;
         end
         S_HEAD_WAIT: begin
            if (stat.slot_free) begin
               cmd.rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ src/max_priority_queue_linear_scan.sv @@
// An enqueue, or any command that is refused, reads the head of the store and then gives its word.
// A removal from a queue of n entries with the maximum at place p scans all n entries of
// the store for the maximum, shifts the tail above p down (none when p is the last place),
// then trims the count, reads the head and replies once the output slot is free.
// One word at a time: a new request is taken only after the last reply has been loaded.
// Reset empties the queue at once; the stored values are not cleared.
module max_priority_queue_linear_scan
   import mpq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

`include "max_priority_queue_linear_scan_defines.svh"

   dp_cmd_type  dp_cmd;
   dp_stat_type dp_stat;

   mpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_cmd   (req_data.cmd),
      .stat      (dp_stat),
      .cmd       (dp_cmd)
   );

   mpq_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (dp_cmd),
      .stat      (dp_stat),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   `MPQ_ASSERT_SAME(a_held_bound, rsp_valid, rsp_data.held <= HELD_W'(DEPTH))
   `MPQ_ASSERT_SAME(a_refused_nothing_removed, rsp_valid && rsp_data.status != ST_OK,
                    rsp_data.removed == '0)
   `MPQ_ASSERT_SAME(a_empty_means_none, rsp_valid && rsp_data.status == ST_EMPTY,
                    rsp_data.held == '0 && rsp_data.oldest == '0)
   `MPQ_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready)

endmodule
